// ===== hw/rtl/outlier_filtered_velocity_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// outlier filtered velocity tracker assertion macros
// shared concurrent assertion forms, sampled on clk, gated by rst_n
// ----------------------------------------------------------------------------
`ifndef OUTLIER_FILTERED_VELOCITY_TRACKER_DEFINES_SVH
`define OUTLIER_FILTERED_VELOCITY_TRACKER_DEFINES_SVH

// same-cycle implication
`define OFVT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ofvt_pkg.sv =====
// ----------------------------------------------------------------------------
// ofvt_pkg
// types, widths and helpers of the outlier filtered velocity tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofvt_pkg;

  localparam int HISTORY_DEPTH = 15;
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int PASS_W = $clog2(HISTORY_DEPTH + 3);
  localparam int DIV_W  = 49;
  localparam int DVS_W  = 24;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int SUM_W  = 33 + IDX_W;
  localparam int T_W    = 64 + IDX_W;
  localparam int MEAN_STEPS = (SUM_W + 2) / 4;
  localparam int MEAN_W     = 4 * MEAN_STEPS;
  localparam int MCNT_W     = $clog2(MEAN_STEPS);
  localparam logic [15:0] GAP_RESET = 16'd100;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_SIGHT,
    CMD_PREDICT,
    CMD_ARM
  } ofvt_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRED,
    ST_SDIV,
    ST_SUM,
    ST_MDIV,
    ST_VAR,
    ST_TEST,
    ST_KDIV,
    ST_DONE
  } ofvt_state_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } ring_entry_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ring_entry_t      wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic [31:0] sat_sample(logic [DIV_W-1:0] q, logic neg);
    logic [31:0] nq;
    nq = -q[31:0];
    if (!neg) begin
      return (q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
    return (q > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : nq;
  endfunction

  function automatic logic [31:0] signed_quot(logic [DIV_W-1:0] q, logic neg);
    logic [31:0] nq;
    nq = -q[31:0];
    return neg ? nq : q[31:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [41:0] v);
    if (v[41:31] != {11{v[41]}}) begin
      return v[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic [SUM_W-1:0] abs_sum(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] nv;
    nv = -v;
    return v[SUM_W-1] ? nv : v;
  endfunction

  // one 4-bit quotient digit of a division by the depth, returns {digit, rem}
  function automatic logic [7:0] depth_div_step(logic [3:0] rem, logic [3:0] nib);
    logic [7:0] t;
    logic [3:0] d;
    logic [7:0] r;
    t = {rem, nib};
    d = '0;
    for (int k = 1; k < 16; k++) begin
      if (t >= 8'(HISTORY_DEPTH * k)) begin
        d = 4'(k);
      end
    end
    r = t - 8'(HISTORY_DEPTH) * {4'b0, d};
    return {d, r[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ofvt_if.sv =====
// ----------------------------------------------------------------------------
// ofvt channel interfaces
// valid/ready word channels for tracker commands and tracker results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ofvt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        now_ms;
  logic signed [31:0] seen_x;
  logic signed [31:0] seen_y;
  logic [23:0]        step_time;
  logic [23:0]        removal_delay_ms;

  modport source (output valid, command, now_ms, seen_x, seen_y, step_time,
                  removal_delay_ms, input ready);
  modport sink   (input valid, command, now_ms, seen_x, seen_y, step_time,
                  removal_delay_ms, output ready);
endinterface

interface ofvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               is_visible;
  logic               remove_due;
  logic [3:0]         kept_samples;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, is_visible, remove_due,
                  kept_samples, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, is_visible, remove_due,
                  kept_samples, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/outlier_filtered_velocity_tracker.sv =====
// ----------------------------------------------------------------------------
// outlier_filtered_velocity_tracker
// 2-d position and sigma-clipped velocity tracking of one object
// ----------------------------------------------------------------------------
// in_ch carries one command word (start, sighting, predict, arm removal);
// out_ch returns one result word per command: position, velocity,
// visibility, removal due flag and kept sample count. cfg_we/cfg_wdata
// write the largest sighting gap in ms (reset 100).
// one command is worked at a time; in_ch.ready is high while idle, also
// when a result still waits in the output register.
// start, arm and a sighting without a sample go from the command state
// straight to the result; predict adds one multiply stage. a sighting with
// a sample runs the serial divider for the sample, a sum pass over the ring
// memory, a mean division by the depth in 4-bit digits, a variance pass and
// an outlier test pass, and then a divider run for the kept mean, which is
// skipped when no sample is kept. in_ch.ready returns at the edge that loads
// the result into the output register; the serial divider and the single
// ring read port set the length of a sighting with a sample.
// reset clears control and object state and the ring valid bits at once;
// no clearing pass. a stalled receiver holds the finished word; the next
// result waits in its last state until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "outlier_filtered_velocity_tracker_defines.svh"

module outlier_filtered_velocity_tracker
  import ofvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ofvt_in_if.sink          in_ch,
  ofvt_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  ofvt_state_t        state_r, state_nxt;
  ofvt_cmd_t          cmd_r;
  logic [31:0]        now_r;
  logic signed [31:0] sx_r, sy_r;
  logic [23:0]        step_r, delay_r;
  logic [15:0]        max_gap_r;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, mean_x_r, mean_y_r;
  logic [31:0]        last_r, deadline_r;
  logic               vis_r, armed_r;
  logic [IDX_W-1:0]   wr_idx_r;

  logic [PASS_W-1:0]  pass_cnt_r;
  logic               in_pass, pass_last;
  logic               rv_r, a_v_r, s_v_r;
  logic signed [32:0] dev_x, dev_y, ndev_x, ndev_y;
  logic [31:0]        ad_x_r, ad_y_r;
  logic signed [31:0] v1x_r, v1y_r, v2x_r, v2y_r;
  logic [63:0]        sq_x_r, sq_y_r;

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, ks_x_r, ks_y_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, ks_x_nxt, ks_y_nxt;
  logic [T_W-1:0]          t_x_r, t_y_r;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic                    hit;

  logic [MEAN_W-1:0]  mq_x_r, mq_y_r, mq_x_nxt, mq_y_nxt;
  logic [3:0]         mr_x_r, mr_y_r;
  logic [7:0]         mstep_x, mstep_y;
  logic [MCNT_W-1:0]  mcnt_r;
  logic               mean_load, mean_last;

  logic signed [56:0] prod_x_r, prod_y_r, pqf_x, pqf_y;
  logic signed [40:0] pq_x, pq_y;
  logic signed [41:0] ps_x, ps_y;
  logic signed [32:0] diff_x, diff_y, ndiff_x, ndiff_y;
  logic [32:0]        dm_x, dm_y, dl;
  logic               take_sample;

  ring_req_t   ring_req;
  ring_entry_t rd_data;
  div_req_t    dreq_x, dreq_y;
  logic        div_start, dneg_x, dneg_y, neg_x_r, neg_y_r;
  logic        dvx_done, dvy_done;
  logic [DIV_W-1:0] q_x, q_y;
  logic [DVS_W-1:0] dvs;

  logic               out_valid_r, out_load;
  logic signed [31:0] o_pos_x_r, o_pos_y_r, o_vel_x_r, o_vel_y_r;
  logic               o_vis_r, o_due_r;
  logic [3:0]         o_kept_r;

  ofvt_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  ofvt_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq_x),
    .done  (dvx_done),
    .quot  (q_x)
  );

  ofvt_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq_y),
    .done  (dvy_done),
    .quot  (q_y)
  );

  // datapath helpers
  always_comb begin
    diff_x  = 33'(sx_r) - 33'(pos_x_r);
    diff_y  = 33'(sy_r) - 33'(pos_y_r);
    ndiff_x = -diff_x;
    ndiff_y = -diff_y;
    dm_x    = diff_x[32] ? ndiff_x : diff_x;
    dm_y    = diff_y[32] ? ndiff_y : diff_y;
    take_sample = ((now_r - last_r) <= {16'b0, max_gap_r}) && (step_r != '0);

    dev_x  = 33'(rd_data.vx) - 33'(mean_x_r);
    dev_y  = 33'(rd_data.vy) - 33'(mean_y_r);
    ndev_x = -dev_x;
    ndev_y = -dev_y;

    hit = s_v_r && ((T_W'(sq_x_r) * T_W'(HISTORY_DEPTH)) < t_x_r)
                && ((T_W'(sq_y_r) * T_W'(HISTORY_DEPTH)) < t_y_r);
    sum_x_nxt = sum_x_r + (s_v_r ? SUM_W'(v2x_r) : '0);
    sum_y_nxt = sum_y_r + (s_v_r ? SUM_W'(v2y_r) : '0);
    ks_x_nxt  = ks_x_r + (hit ? SUM_W'(v2x_r) : '0);
    ks_y_nxt  = ks_y_r + (hit ? SUM_W'(v2y_r) : '0);
    kept_nxt  = kept_r + (hit ? CNT_W'(1) : '0);

    mstep_x  = depth_div_step(mr_x_r, mq_x_r[MEAN_W-1 -: 4]);
    mstep_y  = depth_div_step(mr_y_r, mq_y_r[MEAN_W-1 -: 4]);
    mq_x_nxt = {mq_x_r[MEAN_W-5:0], mstep_x[7:4]};
    mq_y_nxt = {mq_y_r[MEAN_W-5:0], mstep_y[7:4]};

    pqf_x = prod_x_r[56] ? ((prod_x_r + 57'sd65535) >>> 16) : (prod_x_r >>> 16);
    pqf_y = prod_y_r[56] ? ((prod_y_r + 57'sd65535) >>> 16) : (prod_y_r >>> 16);
    pq_x  = pqf_x[40:0];
    pq_y  = pqf_y[40:0];
    ps_x  = 42'(pos_x_r) + 42'(pq_x);
    ps_y  = 42'(pos_y_r) + 42'(pq_y);
    dl    = {1'b0, now_r} + 33'(delay_r);
  end

  assign in_pass   = (state_r == ST_SUM) || (state_r == ST_VAR) || (state_r == ST_TEST);
  assign pass_last = pass_cnt_r == PASS_W'(HISTORY_DEPTH + 2);
  assign mean_last = (state_r == ST_MDIV) && (mcnt_r == MCNT_W'(MEAN_STEPS - 1));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    mean_load = 1'b0;
    out_load  = 1'b0;
    dneg_x    = 1'b0;
    dneg_y    = 1'b0;
    dvs       = step_r;
    dreq_x    = '0;
    dreq_y    = '0;
    ring_req  = '0;

    ring_req.rd_en   = in_pass && (pass_cnt_r < PASS_W'(HISTORY_DEPTH));
    ring_req.rd_addr = pass_cnt_r[IDX_W-1:0];
    ring_req.wr_addr = wr_idx_r;
    ring_req.wr_data = {sat_sample(q_x, neg_x_r), sat_sample(q_y, neg_y_r)};

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r)
          CMD_START: begin
            ring_req.clear = 1'b1;
            state_nxt      = ST_DONE;
          end
          CMD_SIGHT: begin
            if (take_sample) begin
              div_start         = 1'b1;
              dreq_x.dividend   = {dm_x, 16'b0};
              dreq_y.dividend   = {dm_y, 16'b0};
              dneg_x            = diff_x[32];
              dneg_y            = diff_y[32];
              state_nxt         = ST_SDIV;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          CMD_PREDICT: state_nxt = ST_PRED;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_PRED: state_nxt = ST_DONE;
      ST_SDIV: begin
        if (dvx_done) begin
          ring_req.wr_en = 1'b1;
          state_nxt      = ST_SUM;
        end
      end
      ST_SUM: begin
        if (pass_last) begin
          mean_load = 1'b1;
          dneg_x    = sum_x_nxt[SUM_W-1];
          dneg_y    = sum_y_nxt[SUM_W-1];
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (mean_last) begin
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        if (pass_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (pass_last) begin
          if (kept_nxt != '0) begin
            div_start       = 1'b1;
            dreq_x.dividend = DIV_W'(abs_sum(ks_x_nxt));
            dreq_y.dividend = DIV_W'(abs_sum(ks_y_nxt));
            dneg_x          = ks_x_nxt[SUM_W-1];
            dneg_y          = ks_y_nxt[SUM_W-1];
            dvs             = DVS_W'(kept_nxt);
            state_nxt       = ST_KDIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_KDIV: begin
        if (dvx_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    dreq_x.start   = div_start;
    dreq_y.start   = div_start;
    dreq_x.divisor = dvs;
    dreq_y.divisor = dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command word capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      cmd_r   <= ofvt_cmd_t'(in_ch.command);
      now_r   <= in_ch.now_ms;
      sx_r    <= in_ch.seen_x;
      sy_r    <= in_ch.seen_y;
      step_r  <= in_ch.step_time;
      delay_r <= in_ch.removal_delay_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r <= GAP_RESET;
    end else if (cfg_we) begin
      max_gap_r <= cfg_wdata;
    end
  end

  // tracked object state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      vel_x_r    <= '0;
      vel_y_r    <= '0;
      last_r     <= '0;
      vis_r      <= 1'b1;
      armed_r    <= 1'b0;
      deadline_r <= '0;
      wr_idx_r   <= '0;
    end else begin
      case (state_r)
        ST_EXEC: begin
          case (cmd_r)
            CMD_START: begin
              pos_x_r  <= sx_r;
              pos_y_r  <= sy_r;
              vel_x_r  <= '0;
              vel_y_r  <= '0;
              last_r   <= now_r;
              vis_r    <= 1'b1;
              armed_r  <= 1'b0;
              wr_idx_r <= '0;
            end
            CMD_SIGHT: begin
              pos_x_r <= sx_r;
              pos_y_r <= sy_r;
              last_r  <= now_r;
              vis_r   <= 1'b1;
              armed_r <= 1'b0;
            end
            CMD_PREDICT: vis_r <= 1'b0;
            default: begin
              deadline_r <= dl[32] ? 32'hFFFF_FFFF : dl[31:0];
              armed_r    <= 1'b1;
            end
          endcase
        end
        ST_PRED: begin
          pos_x_r <= sat32(ps_x);
          pos_y_r <= sat32(ps_y);
        end
        ST_SDIV: begin
          if (dvx_done) begin
            wr_idx_r <= (wr_idx_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
          end
        end
        ST_KDIV: begin
          if (dvx_done) begin
            vel_x_r <= signed_quot(q_x, neg_x_r);
            vel_y_r <= signed_quot(q_y, neg_y_r);
          end
        end
        default: ;
      endcase
    end
  end

  // ring pass pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_cnt_r <= '0;
      rv_r       <= 1'b0;
      a_v_r      <= 1'b0;
      s_v_r      <= 1'b0;
    end else begin
      pass_cnt_r <= (in_pass && !pass_last) ? pass_cnt_r + 1'b1 : '0;
      rv_r       <= ring_req.rd_en;
      a_v_r      <= rv_r;
      s_v_r      <= a_v_r;
    end
  end

  // mean division by the depth, one 4-bit digit per cycle, msb first
  always_ff @(posedge clk) begin
    if (mean_load) begin
      mq_x_r <= MEAN_W'(abs_sum(sum_x_nxt));
      mq_y_r <= MEAN_W'(abs_sum(sum_y_nxt));
      mr_x_r <= '0;
      mr_y_r <= '0;
      mcnt_r <= '0;
    end else if (state_r == ST_MDIV) begin
      mq_x_r <= mq_x_nxt;
      mq_y_r <= mq_y_nxt;
      mr_x_r <= mstep_x[3:0];
      mr_y_r <= mstep_y[3:0];
      mcnt_r <= mcnt_r + 1'b1;
    end
  end

  // deviation and square stages; sign, predict product and mean registers
  always_ff @(posedge clk) begin
    ad_x_r <= dev_x[32] ? ndev_x[31:0] : dev_x[31:0];
    ad_y_r <= dev_y[32] ? ndev_y[31:0] : dev_y[31:0];
    v1x_r  <= rd_data.vx;
    v1y_r  <= rd_data.vy;
    sq_x_r <= ad_x_r * ad_x_r;
    sq_y_r <= ad_y_r * ad_y_r;
    v2x_r  <= v1x_r;
    v2y_r  <= v1y_r;

    if (div_start || mean_load) begin
      neg_x_r <= dneg_x;
      neg_y_r <= dneg_y;
    end
    if (state_r == ST_EXEC) begin
      prod_x_r <= 57'(vel_x_r) * 57'($signed({1'b0, step_r}));
      prod_y_r <= 57'(vel_y_r) * 57'($signed({1'b0, step_r}));
    end
    if (mean_last) begin
      mean_x_r <= signed_quot(DIV_W'(mq_x_nxt), neg_x_r);
      mean_y_r <= signed_quot(DIV_W'(mq_y_nxt), neg_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
    end else if (state_r == ST_EXEC) begin
      kept_r <= '0;
    end else if (state_r == ST_TEST) begin
      kept_r <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_EXEC: begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        ks_x_r  <= '0;
        ks_y_r  <= '0;
        t_x_r   <= '0;
        t_y_r   <= '0;
      end
      ST_SUM: begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
      end
      ST_VAR: begin
        if (s_v_r) begin
          t_x_r <= t_x_r + T_W'(sq_x_r);
          t_y_r <= t_y_r + T_W'(sq_y_r);
        end
      end
      ST_TEST: begin
        ks_x_r <= ks_x_nxt;
        ks_y_r <= ks_y_nxt;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pos_x_r <= pos_x_r;
      o_pos_y_r <= pos_y_r;
      o_vel_x_r <= vel_x_r;
      o_vel_y_r <= vel_y_r;
      o_vis_r   <= vis_r;
      o_due_r   <= armed_r && (deadline_r < now_r);
      o_kept_r  <= 4'(kept_r);
    end
  end

  assign in_ch.ready         = state_r == ST_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = o_pos_x_r;
  assign out_ch.pos_y        = o_pos_y_r;
  assign out_ch.vel_x        = o_vel_x_r;
  assign out_ch.vel_y        = o_vel_y_r;
  assign out_ch.is_visible   = o_vis_r;
  assign out_ch.remove_due   = o_due_r;
  assign out_ch.kept_samples = o_kept_r;

  `OFVT_ASSERT(a_wr_idx_range, 1'b1, {1'b0, wr_idx_r} < (IDX_W + 1)'(HISTORY_DEPTH), "ring write index out of range")
  `OFVT_ASSERT(a_div_lockstep, 1'b1, dvx_done == dvy_done, "axis dividers out of step")
  `OFVT_ASSERT_NEXT(a_done_loads, state_r == ST_DONE && !out_valid_r, out_valid_r, "finished result not presented")

endmodule

`default_nettype wire

// ===== hw/rtl/ofvt_ring.sv =====
// ----------------------------------------------------------------------------
// ofvt_ring
// velocity sample ring, one write and one registered read port, per-entry
// valid bits so that cleared entries read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofvt_ring
  import ofvt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  ring_req_t  req,
  output ring_entry_t rd_data
);

  ring_entry_t              mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r;
  ring_entry_t              rd_raw_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/ofvt_div.sv =====
// ----------------------------------------------------------------------------
// ofvt_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofvt_div
  import ofvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_new;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_new = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= rem_new[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire
